// ----- sv/rbst_pkg.sv -----
package rbst_pkg;

   localparam int BITS_PER_STEP = 4;
   localparam int DIV_STEPS     = 32 / BITS_PER_STEP;
   // setup stage, divide stages, sign/saturate stage
   localparam int LANE_DEPTH    = DIV_STEPS + 2;
   // input register, lanes, near/far stage, hit stage
   localparam int PIPE_DEPTH    = LANE_DEPTH + 3;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic q_neg;
      logic dir_zero;
      logic num_zero;
      logic num_neg;
      logic ovf;
   } slab_flags_type;

endpackage

// ----- sv/rbst_div_lane.sv -----
module rbst_div_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [31:0] bound,
   input  logic signed [31:0] origin,
   input  logic signed [31:0] dir,
   output logic signed [31:0] slab_t
);

   localparam int NW = 33 + FRAC_BITS;
   localparam int HW = NW - 32;

   logic signed [32:0]     diff;
   logic [32:0]            nmag;
   logic [31:0]            dmag;
   logic [NW-1:0]          num;
   logic [HW-1:0]          num_hi;
   logic                   ovf;

   logic [31:0]                 rem_ff  [0:rbst_pkg::DIV_STEPS];
   logic [31:0]                 quo_ff  [0:rbst_pkg::DIV_STEPS];
   logic [31:0]                 dmag_ff [0:rbst_pkg::DIV_STEPS];
   rbst_pkg::slab_flags_type    flg_ff  [0:rbst_pkg::DIV_STEPS];
   logic signed [31:0]          dist_ff;

   always_comb begin
      diff   = 33'(bound) - 33'(origin);
      nmag   = diff[32] ? 33'(-diff) : 33'(diff);
      dmag   = dir[31] ? 32'(-33'(dir)) : 32'(dir);
      num    = {nmag, {FRAC_BITS{1'b0}}};
      num_hi = num[NW-1:32];
      ovf    = 64'(num_hi) >= 64'(dmag);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]           <= ovf ? 32'd0 : 32'(num_hi);
         quo_ff[0]           <= num[31:0];
         dmag_ff[0]          <= dmag;
         flg_ff[0].q_neg     <= diff[32] ^ dir[31];
         flg_ff[0].dir_zero  <= dmag == 32'd0;
         flg_ff[0].num_zero  <= nmag == 33'd0;
         flg_ff[0].num_neg   <= diff[32];
         flg_ff[0].ovf       <= ovf;
      end
   end

   for (genvar s = 0; s < rbst_pkg::DIV_STEPS; s++) begin : g_step
      logic [31:0] rem_in;
      logic [31:0] quo_in;
      logic [32:0] trial;

      always_comb begin
         rem_in = rem_ff[s];
         quo_in = quo_ff[s];
         trial  = '0;
         for (int k = 0; k < rbst_pkg::BITS_PER_STEP; k++) begin
            trial  = {rem_in, quo_in[31]};
            quo_in = {quo_in[30:0], 1'b0};
            if (trial >= 33'(dmag_ff[s])) begin
               rem_in    = 32'(trial - 33'(dmag_ff[s]));
               quo_in[0] = 1'b1;
            end else begin
               rem_in = trial[31:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s+1]  <= rem_in;
            quo_ff[s+1]  <= quo_in;
            dmag_ff[s+1] <= dmag_ff[s];
            flg_ff[s+1]  <= flg_ff[s];
         end
      end
   end

   logic signed [31:0]       dist_in;
   logic [31:0]              q;
   rbst_pkg::slab_flags_type f;

   always_comb begin
      q = quo_ff[rbst_pkg::DIV_STEPS];
      f = flg_ff[rbst_pkg::DIV_STEPS];
      priority if (f.dir_zero) begin
         priority if (f.num_zero) dist_in = '0;
         else if (f.num_neg)      dist_in = rbst_pkg::SAT_MIN;
         else                     dist_in = rbst_pkg::SAT_MAX;
      end else if (f.q_neg) begin
         if (f.ovf || q > 32'h8000_0000) dist_in = rbst_pkg::SAT_MIN;
         else                             dist_in = 32'(-q);
      end else begin
         if (f.ovf || q[31]) dist_in = rbst_pkg::SAT_MAX;
         else                dist_in = 32'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) dist_ff <= dist_in;
   end

   assign slab_t = dist_ff;

endmodule

// ----- sv/ray_box_slab_test.sv -----
// Ray versus axis-aligned box slab test. One word (box corners, ray origin
// and direction, signed fixed point with FRAC_BITS fraction bits) is taken
// every cycle unless the result side stalls; throughput is one test per
// cycle under the same condition. The six slab dividers resolve four
// quotient bits per stage over eight stages. A stall on the result
// side freezes the whole pipeline and back-pressures the request side.
module ray_box_slab_test #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_direction_x,
   input  logic signed [31:0] req_direction_y,
   input  logic signed [31:0] req_direction_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit
);

   logic                       enable;
   logic [rbst_pkg::PIPE_DEPTH-1:0] vld_ff;
   logic signed [31:0]         lo_ff  [0:2];
   logic signed [31:0]         hi_ff  [0:2];
   logic signed [31:0]         org_ff [0:2];
   logic signed [31:0]         dir_ff [0:2];
   logic signed [31:0]         ta     [0:2];
   logic signed [31:0]         tb     [0:2];
   logic signed [31:0]         near_ff, far_ff, near_in, far_in;
   logic                       hit_ff;

   // advance unless a finished word is held
   assign enable    = !(vld_ff[rbst_pkg::PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[rbst_pkg::PIPE_DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_ff[0]  <= req_box_min_x;   lo_ff[1]  <= req_box_min_y;
         lo_ff[2]  <= req_box_min_z;
         hi_ff[0]  <= req_box_max_x;   hi_ff[1]  <= req_box_max_y;
         hi_ff[2]  <= req_box_max_z;
         org_ff[0] <= req_origin_x;    org_ff[1] <= req_origin_y;
         org_ff[2] <= req_origin_z;
         dir_ff[0] <= req_direction_x; dir_ff[1] <= req_direction_y;
         dir_ff[2] <= req_direction_z;
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbst_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lo (
         .clock (clock), .enable(enable),
         .bound (lo_ff[a]), .origin(org_ff[a]), .dir(dir_ff[a]), .slab_t(ta[a])
      );
      rbst_div_lane #(.FRAC_BITS(FRAC_BITS)) u_hi (
         .clock (clock), .enable(enable),
         .bound (hi_ff[a]), .origin(org_ff[a]), .dir(dir_ff[a]), .slab_t(tb[a])
      );
   end

   always_comb begin
      logic signed [31:0] e, l;
      near_in = rbst_pkg::SAT_MIN;
      far_in  = rbst_pkg::SAT_MAX;
      for (int a = 0; a < 3; a++) begin
         e = (ta[a] < tb[a]) ? ta[a] : tb[a];
         l = (ta[a] < tb[a]) ? tb[a] : ta[a];
         if (a == 0 || e > near_in) near_in = e;
         if (a == 0 || l < far_in)  far_in  = l;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         near_ff <= near_in;
         far_ff  <= far_in;
         hit_ff  <= !(near_ff >= far_ff);
      end
   end

   assign rsp_valid = vld_ff[rbst_pkg::PIPE_DEPTH-1];
   assign rsp_hit   = hit_ff;

endmodule

// ----- sv/rbst_checker.sv -----
module rbst_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_hit
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit))
      else $error("held result word changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held result");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("stall without pending result");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_hit   (rsp_hit)
);

// ----- verif/ray_box_slab_checker.sv -----
`timescale 1ns / 100ps

module ray_box_slab_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_direction_x,
   input  logic signed [31:0] req_direction_y,
   input  logic signed [31:0] req_direction_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_hit,
   output int                 fail_count,
   output int                 pending_hits,
   output int                 hit_total
);

   logic pending_hit_q[$];

   // fixed-point slab distance, truncated toward zero and saturated
   function automatic longint slab_distance(longint bound, longint org, longint dir);
      longint diff;
      logic [127:0] nmag;
      logic [127:0] dmag;
      logic [127:0] quo;
      logic         flip;
      diff = bound - org;
      nmag = (diff < 0) ? -diff : diff;
      dmag = (dir < 0) ? -dir : dir;
      if (dmag == 0) begin
         if (nmag == 0) return 0;
         return (diff < 0) ? longint'(rbst_pkg::SAT_MIN) : longint'(rbst_pkg::SAT_MAX);
      end
      quo = (nmag << FRAC_BITS) / dmag;
      flip = (diff < 0) != (dir < 0);
      if (flip) begin
         if (quo > 128'h8000_0000) return longint'(rbst_pkg::SAT_MIN);
         return -longint'(quo);
      end
      if (quo > 128'h7FFF_FFFF) return longint'(rbst_pkg::SAT_MAX);
      return longint'(quo);
   endfunction

   function automatic logic predict_hit(
      input logic signed [31:0] lo[3], input logic signed [31:0] hi[3],
      input logic signed [31:0] org[3], input logic signed [31:0] dir[3]);
      longint near_t, far_t, ta, tb, t_in, t_out;
      for (int a = 0; a < 3; a++) begin
         ta = slab_distance(lo[a], org[a], dir[a]);
         tb = slab_distance(hi[a], org[a], dir[a]);
         t_in  = (ta < tb) ? ta : tb;
         t_out = (ta < tb) ? tb : ta;
         if (a == 0 || t_in > near_t) near_t = t_in;
         if (a == 0 || t_out < far_t) far_t = t_out;
      end
      return (near_t >= far_t) ? 1'b0 : 1'b1;
   endfunction

   always @(posedge clock) begin
      logic signed [31:0] lo[3], hi[3], org[3], dir[3];
      logic               want;
      if (reset) begin
         fail_count   <= 0;
         pending_hits <= 0;
         hit_total    <= 0;
         pending_hit_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            lo  = '{req_box_min_x, req_box_min_y, req_box_min_z};
            hi  = '{req_box_max_x, req_box_max_y, req_box_max_z};
            org = '{req_origin_x, req_origin_y, req_origin_z};
            dir = '{req_direction_x, req_direction_y, req_direction_z};
            pending_hit_q = {pending_hit_q, predict_hit(lo, hi, org, dir)};
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_hit_q.size() == 0) begin
               $error("unexpected result word, hit %0b", rsp_hit);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_hit_q.pop_front();
               if (rsp_hit !== want) begin
                  $error("field hit: expected %0b, actual %0b", want, rsp_hit);
                  fail_count <= fail_count + 1;
               end
               if (want) hit_total <= hit_total + 1;
            end
         end
         pending_hits <= pending_hit_q.size();
      end
   end
endmodule

// ----- verif/tb_ray_box_slab_test.sv -----
`timescale 1ns / 100ps

module tb_ray_box_slab_test;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [31:0] box_lo[3] = '{0, 0, 0};
   logic signed [31:0] box_hi[3] = '{0, 0, 0};
   logic signed [31:0] ray_org[3] = '{0, 0, 0};
   logic signed [31:0] ray_dir[3] = '{0, 0, 0};
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_hit;
   int                 fail_count, pending_hits, hit_total;
   int                 cycle_count = 0;
   int                 words_sent = 0;
   bit                 stim_done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   ray_box_slab_test dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_box_min_x(box_lo[0]), .req_box_min_y(box_lo[1]), .req_box_min_z(box_lo[2]),
      .req_box_max_x(box_hi[0]), .req_box_max_y(box_hi[1]), .req_box_max_z(box_hi[2]),
      .req_origin_x(ray_org[0]), .req_origin_y(ray_org[1]), .req_origin_z(ray_org[2]),
      .req_direction_x(ray_dir[0]), .req_direction_y(ray_dir[1]),
      .req_direction_z(ray_dir[2]),
      .rsp_valid, .rsp_stall, .rsp_hit
   );

   ray_box_slab_checker chk (
      .clock, .reset, .req_valid, .req_stall,
      .req_box_min_x(box_lo[0]), .req_box_min_y(box_lo[1]), .req_box_min_z(box_lo[2]),
      .req_box_max_x(box_hi[0]), .req_box_max_y(box_hi[1]), .req_box_max_z(box_hi[2]),
      .req_origin_x(ray_org[0]), .req_origin_y(ray_org[1]), .req_origin_z(ray_org[2]),
      .req_direction_x(ray_dir[0]), .req_direction_y(ray_dir[1]),
      .req_direction_z(ray_dir[2]),
      .rsp_valid, .rsp_stall, .rsp_hit,
      .fail_count, .pending_hits, .hit_total
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return rbst_pkg::SAT_MAX;
         1: return rbst_pkg::SAT_MIN;
         2: return 0;
         3: return $urandom();
         4: return 32'(signed'($urandom_range(0, 20)) - 10) <<< 16;
         default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      endcase
   endfunction

   // send one word; hold it until accepted
   task automatic send_word(input logic signed [31:0] lo[3], input logic signed [31:0] hi[3],
                            input logic signed [31:0] org[3],
                            input logic signed [31:0] dir[3]);
      int gap;
      gap = gap_len();
      repeat (gap) @(negedge clock);
      box_lo = lo; box_hi = hi; ray_org = org; ray_dir = dir;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic send_random();
      logic signed [31:0] lo[3], hi[3], org[3], dir[3];
      logic signed [31:0] a, b;
      for (int i = 0; i < 3; i++) begin
         a = pick_value(); b = pick_value();
         // mostly well-ordered boxes, some inverted
         if ($urandom_range(0, 9) != 0 && a > b) begin lo[i] = b; hi[i] = a; end
         else begin lo[i] = a; hi[i] = b; end
         org[i] = pick_value();
         dir[i] = ($urandom_range(0, 9) == 0) ? 0 : pick_value();
      end
      send_word(lo, hi, org, dir);
   endtask

   // result side stalls
   always @(negedge clock) begin
      int stall_left;
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1;
      end else if (cycle_count % 3000 < 600) begin
         rsp_stall <= 0;
      end else begin
         stall_left = gap_len();
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   logic signed [31:0] z3[3] = '{0, 0, 0};
   logic signed [31:0] one3[3] = '{32'sh1_0000, 32'sh1_0000, 32'sh1_0000};

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: unit box from outside along the diagonal, rays along x, zero directions, extremes
      send_word('{32'sh1_0000, 32'sh1_0000, 32'sh1_0000}, '{32'sh2_0000, 32'sh2_0000, 32'sh2_0000},
                z3, one3);
      send_word('{32'sh1_0000, 32'sh1_0000, 32'sh1_0000}, '{32'sh2_0000, 32'sh2_0000, 32'sh2_0000},
                z3, '{-32'sh1_0000, -32'sh1_0000, -32'sh1_0000});
      send_word(z3, one3, '{32'sh8000, 32'sh8000, 32'sh8000}, '{32'sh1_0000, 0, 0});
      send_word(z3, one3, '{32'sh8000, 32'sh2_0000, 32'sh8000}, '{32'sh1_0000, 0, 0});
      send_word(z3, z3, z3, z3);
      send_word(z3, one3, z3, z3);
      send_word('{rbst_pkg::SAT_MIN, rbst_pkg::SAT_MIN, rbst_pkg::SAT_MIN},
                '{rbst_pkg::SAT_MAX, rbst_pkg::SAT_MAX, rbst_pkg::SAT_MAX},
                '{rbst_pkg::SAT_MAX, rbst_pkg::SAT_MIN, 0}, '{1, -1, rbst_pkg::SAT_MIN});
      send_word('{rbst_pkg::SAT_MAX, rbst_pkg::SAT_MAX, rbst_pkg::SAT_MAX},
                '{rbst_pkg::SAT_MIN, rbst_pkg::SAT_MIN, rbst_pkg::SAT_MIN},
                '{rbst_pkg::SAT_MIN, rbst_pkg::SAT_MAX, rbst_pkg::SAT_MIN},
                '{rbst_pkg::SAT_MAX, rbst_pkg::SAT_MIN, 1});
      send_word(one3, z3, '{32'sh8000, 32'sh8000, 32'sh8000}, '{3, -7, 32'sh7FFF_0000});
      send_word('{-1, -1, -1}, '{-1, -1, -1},
                '{rbst_pkg::SAT_MAX, rbst_pkg::SAT_MAX, rbst_pkg::SAT_MAX},
                '{-1, -1, -1});
      send_word(z3, one3, '{-32'sh1_0000, 32'sh8000, 32'sh8000}, '{32'sh1_0000, 0, 0});
      for (int n = 0; n < 1450; n++) begin
         send_random();
         if (n == 700) begin
            wait (pending_hits == 0 && !req_valid);
            @(negedge clock);
         end
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      wait (pending_hits == 0);
      repeat (rbst_pkg::PIPE_DEPTH * 4) @(posedge clock);
      $display("sent %0d ray-box words, %0d expected hits, with random gaps and stalls",
               words_sent, hit_total);
      if (fail_count == 0 && pending_hits == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

// ----- files.f -----
sv/rbst_pkg.sv
sv/rbst_div_lane.sv
sv/ray_box_slab_test.sv
sv/rbst_checker.sv
verif/ray_box_slab_checker.sv
verif/tb_ray_box_slab_test.sv
